// ===== rtl/core/ffas_pkg.sv =====
`default_nettype none

package ffas_pkg;

	localparam int unsigned CmdW     = 3;
	localparam int unsigned ModeW    = 2;
	localparam int unsigned TimeW    = 16;
	localparam int unsigned LevelW   = 8;
	localparam int unsigned PhaseW   = 3;
	localparam int unsigned AddrW    = 3;
	localparam int unsigned DataW    = 32;

	localparam logic [TimeW-1:0]  TIMEOUT_RESET = 16'd10000;
	localparam logic [LevelW-1:0] PRET_START    = 8'd40;
	localparam logic [LevelW-1:0] PRET_LIMIT    = 8'd70;
	localparam logic [LevelW-1:0] DRIVE_REWIND  = 8'd100;
	localparam logic [LevelW-1:0] DRIVE_FORWARD = 8'd20;
	localparam logic [LevelW-1:0] PRET_STEP     = 8'd4;

	typedef enum logic [PhaseW-1:0] {
		PH_IDLE  = 3'd0,
		PH_START = 3'd1,
		PH_HALF  = 3'd2,
		PH_FULL  = 3'd3,
		PH_PRET  = 3'd4
	} phase_t;

	typedef enum logic [CmdW-1:0] {
		CMD_TICK      = 3'd0,
		CMD_NEXT      = 3'd1,
		CMD_AUTO_PRET = 3'd2,
		CMD_MAN_PRET  = 3'd3,
		CMD_UNTENSION = 3'd4,
		CMD_FORWARD   = 3'd5,
		CMD_REWIND    = 3'd6
	} cmd_t;

	typedef enum logic [ModeW-1:0] {
		MODE_NONE = 2'd0,
		MODE_8MM  = 2'd1,
		MODE_S8   = 2'd2
	} film_mode_t;

	typedef enum logic [1:0] {
		EDGE_NONE = 2'd0,
		EDGE_FULL = 2'd1,
		EDGE_HALF = 2'd2
	} edge_kind_t;

	typedef enum logic [0:0] {
		REG_FILM_MODE = 1'b0,
		REG_TIMEOUT   = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [LevelW-1:0] motor_drive;
		logic              stepper_run;
		logic              frame_done;
		logic              timed_out;
		logic              tension_found;
		logic [PhaseW-1:0] phase_now;
	} result_t;

	// x/5*4 via reciprocal 205/1024, exact for all 8-bit x
	function automatic logic [LevelW-1:0] div5_mul4(input logic [LevelW-1:0] x);
		logic [17:0] prod;
		logic [LevelW-1:0] quo;
		prod = {10'd0, x} * 18'd205;
		quo  = prod[17:10];
		return {quo[LevelW-3:0], 2'b00};
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ffas_core.sv =====
`default_nettype none

module ffas_core (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          en,
	input  wire  [ffas_pkg::CmdW-1:0]    cmd,
	input  wire                          opto_level,
	input  wire                          tension_sense,
	input  wire  [ffas_pkg::LevelW-1:0]  manual_level,
	input  wire  [ffas_pkg::ModeW-1:0]   film_mode,
	input  wire  [ffas_pkg::TimeW-1:0]   edge_timeout_ms,
	output ffas_pkg::result_t            res
);
	import ffas_pkg::*;

	phase_t            phase_q, phase_d;
	logic              last_opto_q, last_opto_d;
	logic [TimeW-1:0]  elapsed_q, elapsed_d;
	logic [LevelW-1:0] pret_level_q, pret_level_d;
	logic [LevelW-1:0] motor_q, motor_d;
	logic              stepper_q, stepper_d;
	logic              done, tout, found;

	edge_kind_t        edge_kind;
	logic              rising, falling, expired, waiting;
	logic [LevelW-1:0] pret_scaled;

	assign rising      = opto_level & ~last_opto_q;
	assign falling     = ~opto_level & last_opto_q;
	assign expired     = elapsed_q >= edge_timeout_ms;
	assign waiting     = (phase_q == PH_HALF) || (phase_q == PH_FULL);
	assign pret_scaled = div5_mul4(pret_level_q);

	always_comb begin
		edge_kind = EDGE_NONE;
		case (film_mode)
			MODE_S8: begin
				if (rising) edge_kind = EDGE_HALF;
				else if (falling) edge_kind = EDGE_FULL;
			end
			MODE_8MM: begin
				if (rising) edge_kind = EDGE_FULL;
				else if (falling) edge_kind = EDGE_HALF;
			end
			default: edge_kind = EDGE_NONE;
		endcase
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (cmd)
			CMD_TICK: begin
				case (phase_q)
					PH_START: phase_d = PH_HALF;
					PH_HALF: begin
						if (expired) phase_d = PH_IDLE;
						else if (edge_kind == EDGE_HALF) phase_d = PH_FULL;
					end
					PH_FULL: begin
						if (expired || edge_kind == EDGE_FULL) phase_d = PH_IDLE;
					end
					PH_PRET: begin
						if (pret_level_q != PRET_START && pret_level_q < PRET_LIMIT
							&& tension_sense)
							phase_d = PH_IDLE;
					end
					default: phase_d = phase_q;
				endcase
			end
			CMD_NEXT:      phase_d = PH_START;
			CMD_AUTO_PRET: phase_d = PH_PRET;
			default:       phase_d = phase_q;
		endcase
	end

	// datapath and pulses
	always_comb begin
		last_opto_d  = last_opto_q;
		elapsed_d    = elapsed_q;
		pret_level_d = pret_level_q;
		motor_d      = motor_q;
		stepper_d    = stepper_q;
		done         = 1'b0;
		tout         = 1'b0;
		found        = 1'b0;
		case (cmd)
			CMD_TICK: begin
				if (phase_q == PH_START) begin
					stepper_d   = 1'b1;
					last_opto_d = opto_level;
					elapsed_d   = '0;
				end else if (waiting) begin
					if (expired) begin
						motor_d   = '0;
						stepper_d = 1'b0;
						tout      = 1'b1;
					end else begin
						elapsed_d = elapsed_q + 1'b1;
						if (edge_kind != EDGE_NONE) last_opto_d = ~last_opto_q;
						if (edge_kind == EDGE_HALF) begin
							elapsed_d = '0;
						end else if (edge_kind == EDGE_FULL && phase_q == PH_FULL) begin
							stepper_d = 1'b0;
							done      = 1'b1;
						end
					end
				end else if (phase_q == PH_PRET) begin
					if (pret_level_q == PRET_START) begin
						stepper_d    = 1'b0;
						pret_level_d = pret_level_q + 1'b1;
					end else if (pret_level_q < PRET_LIMIT) begin
						if (tension_sense) begin
							pret_level_d = pret_scaled;
							motor_d      = pret_scaled;
							found        = 1'b1;
						end else begin
							motor_d      = pret_level_q;
							pret_level_d = pret_level_q + PRET_STEP;
						end
					end
				end
			end
			CMD_AUTO_PRET: pret_level_d = PRET_START;
			CMD_MAN_PRET: begin
				pret_level_d = manual_level;
				motor_d      = manual_level;
			end
			CMD_UNTENSION: begin
				stepper_d = 1'b0;
				motor_d   = '0;
			end
			CMD_FORWARD: begin
				motor_d   = DRIVE_FORWARD;
				stepper_d = 1'b1;
			end
			CMD_REWIND: begin
				last_opto_d = opto_level;
				motor_d     = DRIVE_REWIND;
			end
			default: begin
				last_opto_d = last_opto_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			last_opto_q  <= 1'b0;
			elapsed_q    <= '0;
			pret_level_q <= PRET_START;
			motor_q      <= '0;
			stepper_q    <= 1'b0;
		end else if (en) begin
			phase_q      <= phase_d;
			last_opto_q  <= last_opto_d;
			elapsed_q    <= elapsed_d;
			pret_level_q <= pret_level_d;
			motor_q      <= motor_d;
			stepper_q    <= stepper_d;
		end
	end

	assign res.motor_drive   = motor_d;
	assign res.stepper_run   = stepper_d;
	assign res.frame_done    = done;
	assign res.timed_out     = tout;
	assign res.tension_found = found;
	assign res.phase_now     = phase_d;

endmodule

`default_nettype wire

// ===== rtl/core/film_frame_advance_sequencer.sv =====
// film frame advance sequencer
// input channel (in_valid/in_ready) carries one beat per millisecond tick or
// command: cmd, opto_level, tension_sense, manual_level. output channel
// (out_valid/out_ready) returns exactly one result beat per input beat:
// motor_drive, stepper_run, the frame_done/timed_out/tension_found pulses and
// phase_now after that beat.
// a beat is captured in the input register; the sequencer state and the
// result register then update together when the beat advances.
// throughput is one beat per cycle while the receiver takes results;
// nothing in the sequencer limits the rate below that.
// when the receiver stalls, the result register holds and the input
// register still takes one more beat; after that in_ready drops until the
// result is taken.
// reset puts the sequencer idle, motor off, stepper stopped, pretension level
// 40, film mode none and edge timeout 10000 ms. the apb port (film_mode at 0,
// edge_timeout_ms at 4) must be written only while idle; nothing enforces it.
`default_nettype none

module film_frame_advance_sequencer (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [ffas_pkg::AddrW-1:0]   paddr,
	input  wire  [ffas_pkg::DataW-1:0]   pwdata,
	output logic [ffas_pkg::DataW-1:0]   prdata,
	output logic                         pready,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire  [ffas_pkg::CmdW-1:0]    cmd,
	input  wire                          opto_level,
	input  wire                          tension_sense,
	input  wire  [ffas_pkg::LevelW-1:0]  manual_level,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [ffas_pkg::LevelW-1:0]  motor_drive,
	output logic                         stepper_run,
	output logic                         frame_done,
	output logic                         timed_out,
	output logic                         tension_found,
	output logic [ffas_pkg::PhaseW-1:0]  phase_now
);
	import ffas_pkg::*;

	logic [ModeW-1:0]  film_mode_q;
	logic [TimeW-1:0]  timeout_q;
	logic              cfg_wr;
	reg_idx_t          reg_sel;

	logic              valid_s1;
	logic [CmdW-1:0]   cmd_s1;
	logic              opto_s1;
	logic              taut_s1;
	logic [LevelW-1:0] manual_s1;

	logic              advance;
	result_t           res_next;
	result_t           res_s2;
	logic              valid_s2;

	// apb registers
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign reg_sel = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			film_mode_q <= MODE_NONE;
			timeout_q   <= TIMEOUT_RESET;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_FILM_MODE: film_mode_q <= pwdata[ModeW-1:0];
				REG_TIMEOUT:   timeout_q   <= pwdata[TimeW-1:0];
				default:       film_mode_q <= film_mode_q;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_FILM_MODE: prdata = {{(DataW-ModeW){1'b0}}, film_mode_q};
			REG_TIMEOUT:   prdata = {{(DataW-TimeW){1'b0}}, timeout_q};
			default:       prdata = '0;
		endcase
	end

	// input register, then sequencer into the result register
	assign advance  = valid_s1 & (~valid_s2 | out_ready);
	assign in_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1    <= cmd;
			opto_s1   <= opto_level;
			taut_s1   <= tension_sense;
			manual_s1 <= manual_level;
		end
	end

	ffas_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (advance),
		.cmd             (cmd_s1),
		.opto_level      (opto_s1),
		.tension_sense   (taut_s1),
		.manual_level    (manual_s1),
		.film_mode       (film_mode_q),
		.edge_timeout_ms (timeout_q),
		.res             (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid     = valid_s2;
	assign motor_drive   = res_s2.motor_drive;
	assign stepper_run   = res_s2.stepper_run;
	assign frame_done    = res_s2.frame_done;
	assign timed_out     = res_s2.timed_out;
	assign tension_found = res_s2.tension_found;
	assign phase_now     = res_s2.phase_now;

	a_one_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0({frame_done, timed_out, tension_found}))
		else $error("more than one event pulse in a result beat");

	a_timeout_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && timed_out) |->
		(motor_drive == '0 && !stepper_run && phase_now == PH_IDLE))
		else $error("timeout beat does not leave the transport stopped");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (frame_done || tension_found)) |-> (phase_now == PH_IDLE))
		else $error("completion beat does not return to idle");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !out_ready) |-> !in_ready)
		else $error("input accepted with both stages full and output stalled");

endmodule

`default_nettype wire
